// ----- rtl/core/wildcard_pattern_match_macros.svh -----
// Assertion helpers for the wildcard pattern matcher.
// Each check is clocked on clock and held off while reset is high.
`ifndef WILDCARD_PATTERN_MATCH_MACROS_SVH
`define WILDCARD_PATTERN_MATCH_MACROS_SVH

`ifndef NO_ASSERTIONS

`define WPM_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`define WPM_ASSERT_NEVER(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`else

`define WPM_ASSERT(name, prop, msg)

`define WPM_ASSERT_NEVER(name, cond, msg)

`endif

`endif

// ----- rtl/core/wpm_pkg.sv -----
package wpm_pkg;

   localparam int MAX_PATTERN = 64;
   localparam int MAX_TEXT    = 64;

   localparam int PAT_AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int TXT_AW = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
   localparam int PAT_LW = $clog2(MAX_PATTERN + 1);
   localparam int TXT_LW = $clog2(MAX_TEXT + 1);

   typedef logic [1:0] opcode_type;

   localparam opcode_type OP_CLEAR          = 2'd0;
   localparam opcode_type OP_APPEND_PATTERN = 2'd1;
   localparam opcode_type OP_APPEND_TEXT    = 2'd2;
   localparam opcode_type OP_EVALUATE       = 2'd3;

   localparam logic [7:0] CH_ANY_ONE = 8'h3F;
   localparam logic [7:0] CH_ANY_RUN = 8'h2A;

   typedef struct packed {
      logic init;
      logic step;
      logic tail_step;
      logic set_verdict;
      logic verdict;
      logic load;
   } wpm_cmd_type;

   typedef struct packed {
      logic text_done;
      logic pat_done;
      logic step_ok;
      logic tail_star;
   } wpm_status_type;

endpackage

// ----- rtl/core/wpm_ram.sv -----
module wpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/wpm_datapath.sv -----
module wpm_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_accept,
   input  wpm_pkg::opcode_type     req_opcode,
   input  logic [7:0]              req_character,
   input  wpm_pkg::wpm_cmd_type    cmd,
   output wpm_pkg::wpm_status_type status,
   output logic                    rsp_matched,
   output logic                    rsp_too_long
);
   import wpm_pkg::*;

   logic [PAT_LW-1:0] plen_ff, plen_in;
   logic [TXT_LW-1:0] tlen_ff, tlen_in;
   logic              overflow_ff, overflow_in;

   logic [PAT_LW-1:0] pi_ff, pi_in;
   logic [TXT_LW-1:0] ti_ff, ti_in;
   logic              have_star_ff, have_star_in;
   logic [PAT_LW-1:0] star_pos_ff, star_pos_in;
   logic [TXT_LW-1:0] resume_ff, resume_in;
   logic              verdict_ff, verdict_in;
   logic              matched_ff, matched_in;
   logic              too_long_ff, too_long_in;

   logic              pat_wr_en, txt_wr_en;
   logic [7:0]        pat_rd_data, txt_rd_data;
   logic              in_pat, is_match, is_star;

   assign pat_wr_en = req_accept && (req_opcode == OP_APPEND_PATTERN)
                      && (plen_ff < PAT_LW'(MAX_PATTERN));
   assign txt_wr_en = req_accept && (req_opcode == OP_APPEND_TEXT)
                      && (tlen_ff < TXT_LW'(MAX_TEXT));

   wpm_ram #(.WIDTH(8), .DEPTH(MAX_PATTERN)) u_pattern_ram (
      .clock   (clock),
      .wr_en   (pat_wr_en),
      .wr_addr (plen_ff[PAT_AW-1:0]),
      .wr_data (req_character),
      .rd_addr (pi_ff[PAT_AW-1:0]),
      .rd_data (pat_rd_data)
   );

   wpm_ram #(.WIDTH(8), .DEPTH(MAX_TEXT)) u_text_ram (
      .clock   (clock),
      .wr_en   (txt_wr_en),
      .wr_addr (tlen_ff[TXT_AW-1:0]),
      .wr_data (req_character),
      .rd_addr (ti_ff[TXT_AW-1:0]),
      .rd_data (txt_rd_data)
   );

   always_comb begin
      plen_in     = plen_ff;
      tlen_in     = tlen_ff;
      overflow_in = overflow_ff;
      if (req_accept) begin
         case (req_opcode)
            OP_CLEAR: begin
               plen_in     = '0;
               tlen_in     = '0;
               overflow_in = 1'b0;
            end
            OP_APPEND_PATTERN: begin
               if (pat_wr_en) begin
                  plen_in = PAT_LW'(plen_ff + 1'b1);
               end else begin
                  overflow_in = 1'b1;
               end
            end
            OP_APPEND_TEXT: begin
               if (txt_wr_en) begin
                  tlen_in = TXT_LW'(tlen_ff + 1'b1);
               end else begin
                  overflow_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign in_pat   = pi_ff < plen_ff;
   assign is_match = in_pat && ((pat_rd_data == CH_ANY_ONE) || (pat_rd_data == txt_rd_data));
   assign is_star  = in_pat && (pat_rd_data == CH_ANY_RUN);

   // A literal or single-byte wildcard match wins over star handling.
   always_comb begin
      pi_in        = pi_ff;
      ti_in        = ti_ff;
      have_star_in = have_star_ff;
      star_pos_in  = star_pos_ff;
      resume_in    = resume_ff;
      if (cmd.init) begin
         pi_in        = '0;
         ti_in        = '0;
         have_star_in = 1'b0;
      end else if (cmd.step) begin
         if (is_match) begin
            pi_in = PAT_LW'(pi_ff + 1'b1);
            ti_in = TXT_LW'(ti_ff + 1'b1);
         end else if (is_star) begin
            have_star_in = 1'b1;
            star_pos_in  = pi_ff;
            pi_in        = PAT_LW'(pi_ff + 1'b1);
            resume_in    = ti_ff;
         end else begin
            pi_in     = PAT_LW'(star_pos_ff + 1'b1);
            resume_in = TXT_LW'(resume_ff + 1'b1);
            ti_in     = TXT_LW'(resume_ff + 1'b1);
         end
      end else if (cmd.tail_step) begin
         pi_in = PAT_LW'(pi_ff + 1'b1);
      end
   end

   assign verdict_in  = cmd.set_verdict ? cmd.verdict : verdict_ff;
   assign matched_in  = cmd.load ? verdict_ff : matched_ff;
   assign too_long_in = cmd.load ? overflow_ff : too_long_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff     <= '0;
         tlen_ff     <= '0;
         overflow_ff <= 1'b0;
      end else begin
         plen_ff     <= plen_in;
         tlen_ff     <= tlen_in;
         overflow_ff <= overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      pi_ff        <= pi_in;
      ti_ff        <= ti_in;
      have_star_ff <= have_star_in;
      star_pos_ff  <= star_pos_in;
      resume_ff    <= resume_in;
      verdict_ff   <= verdict_in;
      matched_ff   <= matched_in;
      too_long_ff  <= too_long_in;
   end

   assign status.text_done = (ti_ff == tlen_ff);
   assign status.pat_done  = (pi_ff == plen_ff);
   assign status.step_ok   = is_match || is_star || have_star_ff;
   assign status.tail_star = (pat_rd_data == CH_ANY_RUN);

   assign rsp_matched  = matched_ff;
   assign rsp_too_long = too_long_ff;

endmodule

// ----- rtl/core/wpm_ctrl.sv -----
`include "wildcard_pattern_match_macros.svh"

module wpm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_accept,
   input  wpm_pkg::opcode_type     req_opcode,
   input  logic                    rsp_tready,
   input  wpm_pkg::wpm_status_type status,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   output wpm_pkg::wpm_cmd_type    cmd
);
   import wpm_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_FETCH  = 3'd1;
   localparam logic [2:0] ST_STEP   = 3'd2;
   localparam logic [2:0] ST_TFETCH = 3'd3;
   localparam logic [2:0] ST_TSTEP  = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_opcode == OP_EVALUATE)) begin
               cmd.init = 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = status.text_done ? ST_TFETCH : ST_STEP;
         end
         ST_STEP: begin
            if (status.step_ok) begin
               cmd.step = 1'b1;
               state_in = ST_FETCH;
            end else begin
               cmd.set_verdict = 1'b1;
               cmd.verdict     = 1'b0;
               state_in        = ST_DONE;
            end
         end
         ST_TFETCH: begin
            if (status.pat_done) begin
               cmd.set_verdict = 1'b1;
               cmd.verdict     = 1'b1;
               state_in        = ST_DONE;
            end else begin
               state_in = ST_TSTEP;
            end
         end
         ST_TSTEP: begin
            if (status.tail_star) begin
               cmd.tail_step = 1'b1;
               state_in      = ST_TFETCH;
            end else begin
               cmd.set_verdict = 1'b1;
               cmd.verdict     = 1'b0;
               state_in        = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   `WPM_ASSERT(a_load_slot_free, cmd.load |-> (!rsp_valid_ff || rsp_tready), "result overwritten")
   `WPM_ASSERT_NEVER(a_step_past_text, (state_ff == ST_STEP) && status.text_done, "step past text end")
   `WPM_ASSERT_NEVER(a_tail_past_pattern, (state_ff == ST_TSTEP) && status.pat_done, "tail past pattern end")
   `WPM_ASSERT(a_result_from_done, $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE), "result outside done")

endmodule

// ----- rtl/core/wildcard_pattern_match.sv -----
// Channel  Direction  tvalid/tready          tuser          tdata
// req      in         req_tvalid/req_tready  [1:0] opcode   [7:0] character
// rsp      out        rsp_tvalid/rsp_tready  -              [0] matched, [1] too_long
//
// Clear and append transactions are taken in idle; evaluate runs a walk over the stores.
// Each walk step and each trailing-star step passes a fetch state, which waits for the
// registered RAM read, and then a step state; a walk has up to roughly (P + 1) * T steps
// for pattern length P and text length T.
// Reset clears the lengths and the overflow flag; no clearing pass over the stores.
// A held result waits in the output register while clear and append transactions go on.
module wildcard_pattern_match (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,  // [7:0] character
   input  logic [1:0] req_tuser,  // [1:0] opcode
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata   // [0] matched, [1] too_long, [7:2] zero
);
   import wpm_pkg::*;

   logic           req_accept;
   wpm_cmd_type    cmd;
   wpm_status_type status;
   logic           matched;
   logic           too_long;

   assign req_accept = req_tvalid && req_tready;

   wpm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_opcode (req_tuser),
      .rsp_tready (rsp_tready),
      .status     (status),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .cmd        (cmd)
   );

   wpm_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_accept    (req_accept),
      .req_opcode    (req_tuser),
      .req_character (req_tdata),
      .cmd           (cmd),
      .status        (status),
      .rsp_matched   (matched),
      .rsp_too_long  (too_long)
   );

   assign rsp_tdata = {6'b000000, too_long, matched};

endmodule
